FILE: rtl/cst_pkg.sv
// ---------------------------------------------------------------------------
// cst_pkg: shared types and constants of the cyclometer tracker
// Transaction payloads, configuration layout, sequencer states, divider
// request and response groups, and the MET step table.
// ---------------------------------------------------------------------------
package cst_pkg;

  // Configuration register indexes.
  localparam logic [2:0] CFG_WHEEL_CIRC  = 3'd0;
  localparam logic [2:0] CFG_RIDER_KG    = 3'd1;
  localparam logic [2:0] CFG_DEBOUNCE    = 3'd2;
  localparam logic [2:0] CFG_STOP_TMO    = 3'd3;
  localparam logic [2:0] CFG_UPD_PERIOD  = 3'd4;

  // Configuration reset values.
  localparam logic [11:0] RST_WHEEL_CIRC = 12'd2100;
  localparam logic [7:0]  RST_RIDER_KG   = 8'd55;
  localparam logic [9:0]  RST_DEBOUNCE   = 10'd50;
  localparam logic [15:0] RST_STOP_TMO   = 16'd2000;
  localparam logic [15:0] RST_UPD_PERIOD = 16'd1000;

  // Speed in 0.01 km/h is circumference_mm * 360 / period_ms.
  localparam logic [8:0]  SPEED_SCALE = 9'd360;
  localparam logic [15:0] SPEED_MAX   = 16'hFFFF;

  // Divider dividend width: covers circumference * 360 and any ring sum.
  localparam int DIV_W     = 21;
  localparam int DIV_CNT_W = $clog2(DIV_W);

  typedef enum logic [1:0] {
    MODE_READY    = 2'd0,
    MODE_RUNNING  = 2'd1,
    MODE_FINISHED = 2'd2
  } mode_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_BUTTON,
    S_SENSOR,
    S_SPD_START,
    S_SPD_WAIT,
    S_SPD_STORE,
    S_UPD_CHK,
    S_UPD_STOP,
    S_AVG_SUM,
    S_AVG_DIV,
    S_AVG_WAIT,
    S_AVG_DONE,
    S_ENERGY,
    S_OUT
  } state_e;

  typedef struct packed {
    logic sensor_low;
    logic button_press;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  session_mode;
    logic [15:0] current_speed;
    logic [15:0] smoothed_speed;
    logic [15:0] peak_speed;
    logic [15:0] session_avg_speed;
    logic [31:0] energy_units;
    logic        new_sample;
  } out_item_t;

  typedef struct packed {
    logic [2:0]  index;
    logic [15:0] value;
  } cfg_write_t;

  typedef struct packed {
    logic [11:0] wheel_circumference_mm;
    logic [7:0]  rider_weight_kg;
    logic [9:0]  debounce_ms;
    logic [15:0] stop_timeout_ms;
    logic [15:0] update_period_ms;
  } cfg_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [31:0]      divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

  // MET step in tenths for an average speed in 0.01 km/h.
  function automatic logic [6:0] met_tenths(logic [15:0] v);
    logic [6:0] m;
    if (v < 16'd500) begin
      m = 7'd25;
    end else if (v < 16'd1000) begin
      m = 7'd40;
    end else if (v < 16'd1500) begin
      m = 7'd60;
    end else if (v < 16'd2000) begin
      m = 7'd80;
    end else if (v < 16'd2500) begin
      m = 7'd100;
    end else begin
      m = 7'd120;
    end
    return m;
  endfunction

endpackage

FILE: rtl/cst_stream_if.sv
// ---------------------------------------------------------------------------
// cst_stream_if: valid/ready channel
// Carries one payload of type T per transaction; the source drives valid
// and data, the sink drives ready.
// ---------------------------------------------------------------------------
interface cst_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/cyclometer_speed_energy_tracker.sv
// ---------------------------------------------------------------------------
// cyclometer_speed_energy_tracker: wheel speed and energy tracker
// One millisecond tick per input transaction, one status result per tick.
// ---------------------------------------------------------------------------
// Each input transaction is one millisecond tick carrying the wheel sensor
// level and a qualified button press, and each tick returns exactly one
// result transaction with the session mode, current, smoothed, peak and
// session average speeds in 0.01 km/h, the energy count (kcal is the count
// divided by 36000) and a flag for a new speed sample. A tick takes longest
// when a wheel edge and a periodic update fall in the same tick. Its length
// is set by the single 21-step restoring divider, which the speed calculation
// and the ring average use one after the other, and by the ring scan, which
// reads one entry per cycle. The input is not ready while a tick is being
// worked on; a finished result waits in the output register, so the next
// tick can be taken while the previous result is still pending downstream.
// Configuration registers are written through the configuration channel,
// which is always ready, and should only be written while no tick is in
// flight.
module cyclometer_speed_energy_tracker #(
  parameter int RING_DEPTH = 5
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  cst_stream_if.sink   in_if,
  cst_stream_if.source out_if,
  cst_stream_if.sink   cfg_if
);
  import cst_pkg::*;

  cfg_t      cfg_q;
  logic      res_valid;
  logic      res_ready;
  out_item_t res_item;
  logic      obuf_valid_q;
  out_item_t obuf_q;

  // The configuration channel takes a write transaction every cycle.
  // Writes to indexes beyond the register list are dropped.
  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.wheel_circumference_mm <= RST_WHEEL_CIRC;
      cfg_q.rider_weight_kg        <= RST_RIDER_KG;
      cfg_q.debounce_ms            <= RST_DEBOUNCE;
      cfg_q.stop_timeout_ms        <= RST_STOP_TMO;
      cfg_q.update_period_ms       <= RST_UPD_PERIOD;
    end else if (cfg_if.valid) begin
      unique case (cfg_if.data.index)
        CFG_WHEEL_CIRC: cfg_q.wheel_circumference_mm <= cfg_if.data.value[11:0];
        CFG_RIDER_KG:   cfg_q.rider_weight_kg        <= cfg_if.data.value[7:0];
        CFG_DEBOUNCE:   cfg_q.debounce_ms            <= cfg_if.data.value[9:0];
        CFG_STOP_TMO:   cfg_q.stop_timeout_ms        <= cfg_if.data.value;
        CFG_UPD_PERIOD: cfg_q.update_period_ms       <= cfg_if.data.value;
        default: begin
        end
      endcase
    end
  end

  // The sequencer holds all session state and runs one tick at a time.
  cst_core #(
    .RING_DEPTH (RING_DEPTH)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_if.valid),
    .in_item_i   (in_if.data),
    .in_ready_o  (in_if.ready),
    .res_valid_o (res_valid),
    .res_item_o  (res_item),
    .res_ready_i (res_ready)
  );

  // Output register: the core hands over a result when the register is
  // empty or is being emptied in the same cycle.
  assign res_ready = !obuf_valid_q || out_if.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      obuf_valid_q <= 1'b0;
    end else if (res_ready) begin
      obuf_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      obuf_q <= res_item;
    end
  end

  assign out_if.valid = obuf_valid_q;
  assign out_if.data  = obuf_q;

  // A tick always passes through further states after the accepting one, so
  // the input drops ready right after a transaction.
  a_busy_after_accept: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    in_if.valid && in_if.ready |=> !in_if.ready
  ) else $error("input ready right after an accepted tick");

  // The peak is a running maximum of the smoothed speed and both are
  // cleared together at session start.
  a_peak_covers_smooth: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_if.valid |-> out_if.data.peak_speed >= out_if.data.smoothed_speed
  ) else $error("peak speed below smoothed speed");

  // Speed samples are only taken while a session runs.
  a_sample_when_running: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && out_if.data.new_sample |->
      out_if.data.session_mode == MODE_RUNNING
  ) else $error("new sample reported outside a running session");

endmodule

FILE: rtl/cst_divider.sv
// ---------------------------------------------------------------------------
// cst_divider: shared restoring divider
// Unsigned DIV_W-bit dividend over a 32-bit divisor, one quotient bit per
// cycle; done pulses in the cycle after the last step.
// ---------------------------------------------------------------------------
module cst_divider (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cst_pkg::div_req_t req_i,
  output cst_pkg::div_rsp_t rsp_o
);
  import cst_pkg::*;

  logic                 busy_q;
  logic                 done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [DIV_W-1:0]     rem_q;
  logic [DIV_W-1:0]     quo_q;
  logic [31:0]          dvs_q;

  logic [DIV_W:0]       trial;
  logic                 ge;
  logic [DIV_W:0]       diff;

  // The partial remainder never exceeds the dividend, so it fits DIV_W bits.
  assign trial = {rem_q, quo_q[DIV_W-1]};
  assign ge    = 32'(trial) >= dvs_q;
  assign diff  = trial - dvs_q[DIV_W:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == DIV_CNT_W'(DIV_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      quo_q <= req_i.dividend;
      dvs_q <= req_i.divisor;
    end else if (busy_q) begin
      rem_q <= ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
      quo_q <= {quo_q[DIV_W-2:0], ge};
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

FILE: rtl/cst_core.sv
// ---------------------------------------------------------------------------
// cst_core: tick sequencer and session datapath
// Walks one tick through button, sensor, speed and periodic update steps,
// sharing one divider for the speed and the ring average.
// ---------------------------------------------------------------------------
module cst_core #(
  parameter int RING_DEPTH = 5
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cst_pkg::cfg_t      cfg_i,
  input  logic               in_valid_i,
  input  cst_pkg::in_item_t  in_item_i,
  output logic               in_ready_o,
  output logic               res_valid_o,
  output cst_pkg::out_item_t res_item_o,
  input  logic               res_ready_i
);
  import cst_pkg::*;

  localparam int PTR_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int CNT_W = $clog2(RING_DEPTH + 1);
  localparam int SUM_W = 16 + CNT_W;

  state_e state_q, state_d;
  mode_e  mode_q;

  logic [31:0]      time_q;
  logic [31:0]      edge_time_q;
  logic             edge_valid_q;
  logic [31:0]      deb_time_q;
  logic             magnet_q;
  logic [15:0]      ring_q [RING_DEPTH];
  logic [PTR_W-1:0] ptr_q;
  logic [15:0]      speed_now_q;
  logic [15:0]      smooth_q;
  logic [15:0]      peak_q;
  logic [15:0]      sess_q;
  logic [31:0]      energy_q;
  logic [31:0]      last_upd_q;
  logic             sensor_q;
  logic             press_q;
  logic             sample_q;
  logic             for_session_q;
  logic [SUM_W-1:0] sum_q;
  logic [CNT_W-1:0] cnt_q;
  logic [PTR_W-1:0] scan_q;
  logic [15:0]      val_q;
  logic [14:0]      add_q;

  logic [20:0]      num;
  logic [31:0]      delta;
  logic             edge_seen;
  logic             deb_ok;
  logic             upd_due;
  logic             stopped;
  logic             scan_last;
  logic [15:0]      quot_sat;
  logic [32:0]      esum;
  div_req_t         div_req;
  div_rsp_t         div_rsp;

  assign num       = DIV_W'(cfg_i.wheel_circumference_mm) * DIV_W'(SPEED_SCALE);
  assign delta     = time_q - edge_time_q;
  assign edge_seen = sensor_q && !magnet_q;
  assign deb_ok    = (time_q - deb_time_q) > 32'(cfg_i.debounce_ms);
  assign upd_due   = (time_q - last_upd_q) >= 32'(cfg_i.update_period_ms);
  assign stopped   = !edge_valid_q || (delta > 32'(cfg_i.stop_timeout_ms));
  assign scan_last = scan_q == PTR_W'(RING_DEPTH - 1);
  assign quot_sat  = (|div_rsp.quotient[DIV_W-1:16]) ? SPEED_MAX
                                                     : div_rsp.quotient[15:0];
  assign esum      = {1'b0, energy_q} + 33'(add_q);

  cst_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d          = state_q;
    in_ready_o       = 1'b0;
    res_valid_o      = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = num;
    div_req.divisor  = delta;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          state_d = S_BUTTON;
        end
      end
      S_BUTTON: begin
        if (press_q && mode_q == MODE_RUNNING) begin
          state_d = S_AVG_SUM;
        end else begin
          state_d = S_SENSOR;
        end
      end
      S_SENSOR: begin
        if (mode_q == MODE_RUNNING && edge_seen && deb_ok && edge_valid_q) begin
          state_d = S_SPD_START;
        end else begin
          state_d = S_UPD_CHK;
        end
      end
      S_SPD_START: begin
        if (num != '0 && delta != '0) begin
          div_req.start = 1'b1;
          state_d       = S_SPD_WAIT;
        end else begin
          state_d = S_SPD_STORE;
        end
      end
      S_SPD_WAIT: begin
        if (div_rsp.done) begin
          state_d = S_SPD_STORE;
        end
      end
      S_SPD_STORE: state_d = S_UPD_CHK;
      S_UPD_CHK: begin
        if (mode_q == MODE_RUNNING && upd_due) begin
          state_d = S_UPD_STOP;
        end else begin
          state_d = S_OUT;
        end
      end
      S_UPD_STOP: state_d = S_AVG_SUM;
      S_AVG_SUM: begin
        if (scan_last) begin
          state_d = S_AVG_DIV;
        end
      end
      S_AVG_DIV: begin
        div_req.dividend = DIV_W'(sum_q);
        div_req.divisor  = 32'(cnt_q);
        if (cnt_q != '0) begin
          div_req.start = 1'b1;
          state_d       = S_AVG_WAIT;
        end else begin
          state_d = S_AVG_DONE;
        end
      end
      S_AVG_WAIT: begin
        if (div_rsp.done) begin
          state_d = S_AVG_DONE;
        end
      end
      S_AVG_DONE: state_d = for_session_q ? S_OUT : S_ENERGY;
      S_ENERGY:   state_d = S_OUT;
      S_OUT: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q        <= MODE_READY;
      time_q        <= '0;
      edge_time_q   <= '0;
      edge_valid_q  <= 1'b0;
      deb_time_q    <= '0;
      magnet_q      <= 1'b0;
      for (int i = 0; i < RING_DEPTH; i++) begin
        ring_q[i] <= '0;
      end
      ptr_q         <= '0;
      speed_now_q   <= '0;
      smooth_q      <= '0;
      peak_q        <= '0;
      sess_q        <= '0;
      energy_q      <= '0;
      last_upd_q    <= '0;
      sensor_q      <= 1'b0;
      press_q       <= 1'b0;
      sample_q      <= 1'b0;
      for_session_q <= 1'b0;
      sum_q         <= '0;
      cnt_q         <= '0;
      scan_q        <= '0;
      val_q         <= '0;
      add_q         <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            time_q   <= time_q + 32'd1;
            sensor_q <= in_item_i.sensor_low;
            press_q  <= in_item_i.button_press;
            sample_q <= 1'b0;
          end
        end
        S_BUTTON: begin
          sum_q         <= '0;
          cnt_q         <= '0;
          scan_q        <= '0;
          for_session_q <= 1'b1;
          if (press_q) begin
            unique case (mode_q)
              MODE_READY: begin
                mode_q       <= MODE_RUNNING;
                energy_q     <= '0;
                speed_now_q  <= '0;
                smooth_q     <= '0;
                peak_q       <= '0;
                sess_q       <= '0;
                edge_valid_q <= 1'b0;
                for (int i = 0; i < RING_DEPTH; i++) begin
                  ring_q[i] <= '0;
                end
              end
              MODE_RUNNING: mode_q <= MODE_FINISHED;
              default:      mode_q <= MODE_READY;
            endcase
          end
        end
        S_SENSOR: begin
          if (mode_q == MODE_RUNNING) begin
            if (edge_seen) begin
              magnet_q <= 1'b1;
              if (deb_ok) begin
                deb_time_q <= time_q;
                // With a prior edge the speed step records this edge itself.
                if (!edge_valid_q) begin
                  edge_time_q  <= time_q;
                  edge_valid_q <= 1'b1;
                end
              end
            end else if (!sensor_q) begin
              magnet_q <= 1'b0;
            end
          end
        end
        S_SPD_START: begin
          edge_time_q  <= time_q;
          edge_valid_q <= 1'b1;
          val_q        <= (num == '0) ? 16'd0 : SPEED_MAX;
        end
        S_SPD_WAIT: begin
          if (div_rsp.done) begin
            val_q <= quot_sat;
          end
        end
        S_SPD_STORE: begin
          speed_now_q   <= val_q;
          ring_q[ptr_q] <= val_q;
          ptr_q         <= (ptr_q == PTR_W'(RING_DEPTH - 1)) ? '0 : ptr_q + 1'b1;
          sample_q      <= 1'b1;
        end
        S_UPD_CHK: begin
          if (mode_q == MODE_RUNNING && upd_due) begin
            last_upd_q <= time_q;
          end
        end
        S_UPD_STOP: begin
          if (stopped) begin
            speed_now_q <= '0;
          end
          for_session_q <= 1'b0;
          sum_q         <= '0;
          cnt_q         <= '0;
          scan_q        <= '0;
        end
        S_AVG_SUM: begin
          if (ring_q[scan_q] != '0) begin
            sum_q <= sum_q + SUM_W'(ring_q[scan_q]);
            cnt_q <= cnt_q + 1'b1;
          end
          if (!scan_last) begin
            scan_q <= scan_q + 1'b1;
          end
        end
        S_AVG_DIV: begin
          val_q <= '0;
        end
        S_AVG_WAIT: begin
          if (div_rsp.done) begin
            val_q <= div_rsp.quotient[15:0];
          end
        end
        S_AVG_DONE: begin
          if (for_session_q) begin
            sess_q <= val_q;
          end else begin
            smooth_q <= val_q;
            if (val_q > peak_q) begin
              peak_q <= val_q;
            end
            add_q <= 15'(met_tenths(val_q)) * 15'(cfg_i.rider_weight_kg);
          end
        end
        S_ENERGY: begin
          energy_q <= esum[32] ? 32'hFFFF_FFFF : esum[31:0];
        end
        default: begin
        end
      endcase
    end
  end

  assign res_item_o.session_mode      = mode_q;
  assign res_item_o.current_speed     = speed_now_q;
  assign res_item_o.smoothed_speed    = smooth_q;
  assign res_item_o.peak_speed        = peak_q;
  assign res_item_o.session_avg_speed = sess_q;
  assign res_item_o.energy_units      = energy_q;
  assign res_item_o.new_sample        = sample_q;

endmodule
